[design/pcm_pkg.sv]
// Package for the PWM capture measurement block: field widths and constants.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pcm_pkg;

   localparam int CNT_BITS  = 16;                   // capture counter and tick fields
   localparam int RATE_BITS = 26;                   // tick rate / frequency
   localparam int DUTY_BITS = 15;                   // duty percent in Q8
   localparam int NUM_BITS  = CNT_BITS + DUTY_BITS; // dividend width of the shared divider

   localparam logic [DUTY_BITS-1:0] DUTY_FULL  = 15'd25600;    // 100 percent in Q8
   localparam logic [RATE_BITS-1:0] RATE_RESET = 26'd2000000;

endpackage

`default_nettype wire

[design/pcm_req_if.sv]
// Input channel of the PWM capture measurement block: one capture timestamp.
// Depends on pcm_pkg.
`default_nettype none

interface pcm_req_if
   import pcm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CNT_BITS-1:0] capture_time;

   modport source (output valid, output capture_time, input ready);
   modport sink   (input valid, input capture_time, output ready);
endinterface

`default_nettype wire

[design/pcm_rsp_if.sv]
// Result channel of the PWM capture measurement block.
// Depends on pcm_pkg.
`default_nettype none

interface pcm_rsp_if
   import pcm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 arm_rising;
   logic                 result_valid;
   logic [CNT_BITS-1:0]  on_time;
   logic [CNT_BITS-1:0]  period_ticks;
   logic [DUTY_BITS-1:0] duty_q8;
   logic [RATE_BITS-1:0] frequency_hz;

   modport source (output valid, output arm_rising, output result_valid, output on_time,
                   output period_ticks, output duty_q8, output frequency_hz, input ready);
   modport sink   (input valid, input arm_rising, input result_valid, input on_time,
                   input period_ticks, input duty_q8, input frequency_hz, output ready);
endinterface

`default_nettype wire

[design/pwm_capture_measure_core.sv]
// PWM period/duty measurement from input-capture timestamps, top level.
// Depends on pcm_pkg, pcm_req_if and pcm_rsp_if.
//
// Usage:
//   req_ch  : one capture timestamp per transfer, taken at the edge that the
//             previous result armed (arm_rising). Edges of one PWM period:
//             rise (start), fall, rise (on time and period are updated).
//   rsp_ch  : one result per request: next edge to arm, a flag for a fresh
//             measurement, the held on time and period, duty (percent Q8,
//             saturated at 100) and frequency in Hz.
//   csr_*   : tick rate in Hz; user writes only while the block is idle, unchecked.
// Timing: one restoring divider (one quotient bit per cycle) is shared by
//   the duty and the frequency division. After a request transfer the
//   sequencer runs load, duty, frequency and done; the block takes the next
//   request only once the result has entered the output register.
// The output register frees the divider from the receiver: a stalled result
//   holds, the next request is taken, and its result waits in the final
//   sequencer step until the output register is free.
// Reset (synchronous, active high) returns to the first rising edge, clears
//   the held values and restores the tick rate to 2000000.
`default_nettype none

module pwm_capture_measure_core
   import pcm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   pcm_req_if.sink                   req_ch,
   pcm_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [RATE_BITS-1:0] csr_wr_data
);

   localparam int STEP_BITS = $clog2(NUM_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_BITS - 1);

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_FALL  = 2'd1,
      PH_RISE  = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_DUTY = 5'b00100,
      ST_FREQ = 5'b01000,
      ST_DONE = 5'b10000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [RATE_BITS-1:0] rate_ff;
   logic [CNT_BITS-1:0]  first_rise_ff, first_rise_in;
   logic [CNT_BITS-1:0]  fall_ff, fall_in;
   logic [CNT_BITS-1:0]  on_ff, on_in;
   logic [CNT_BITS-1:0]  per_ff, per_in;
   logic                 arm_ff, arm_in;
   logic                 meas_ff, meas_in;

   // shared divider
   logic [NUM_BITS-1:0]  num_ff, num_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [CNT_BITS:0]    rem_sh;
   logic [CNT_BITS:0]    diff;
   logic                 take;
   logic [NUM_BITS-1:0]  quot;
   logic                 per_zero;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 o_arm_ff, o_meas_ff;
   logic [CNT_BITS-1:0]  o_on_ff, o_per_ff;
   logic [DUTY_BITS-1:0] o_duty_ff;
   logic [RATE_BITS-1:0] o_freq_ff;
   logic                 out_load;
   logic                 req_xfer;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.arm_rising   = o_arm_ff;
   assign rsp_ch.result_valid = o_meas_ff;
   assign rsp_ch.on_time      = o_on_ff;
   assign rsp_ch.period_ticks = o_per_ff;
   assign rsp_ch.duty_q8      = o_duty_ff;
   assign rsp_ch.frequency_hz = o_freq_ff;

   // one restoring step per cycle
   assign rem_sh   = {rem_ff, num_ff[NUM_BITS-1]};
   assign diff     = rem_sh - {1'b0, per_ff};
   assign take     = !diff[CNT_BITS];
   assign quot     = {num_ff[NUM_BITS-2:0], take};
   assign per_zero = (per_ff == '0);

   // edge cycle bookkeeping
   always_comb begin
      phase_in      = phase_ff;
      first_rise_in = first_rise_ff;
      fall_in       = fall_ff;
      on_in         = on_ff;
      per_in        = per_ff;
      arm_in        = arm_ff;
      meas_in       = meas_ff;
      if (req_xfer) begin
         meas_in = 1'b0;
         unique case (phase_ff)
            PH_START: begin
               first_rise_in = req_ch.capture_time;
               phase_in      = PH_FALL;
               arm_in        = 1'b0;
            end
            PH_FALL: begin
               fall_in  = req_ch.capture_time;
               phase_in = PH_RISE;
               arm_in   = 1'b1;
            end
            default: begin
               on_in    = fall_ff - first_rise_ff;
               per_in   = req_ch.capture_time - first_rise_ff;
               phase_in = PH_START;
               arm_in   = 1'b1;
               meas_in  = 1'b1;
            end
         endcase
      end
   end

   // sequencer and divider
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      duty_in  = duty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            num_in   = NUM_BITS'(on_ff) * NUM_BITS'(DUTY_FULL);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DUTY;
         end
         ST_DUTY, ST_FREQ: begin
            num_in  = quot;
            rem_in  = take ? diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               if (state_ff == ST_DUTY) begin
                  priority if (per_zero) begin
                     duty_in = '0;
                  end else if (quot > NUM_BITS'(DUTY_FULL)) begin
                     duty_in = DUTY_FULL;
                  end else begin
                     duty_in = quot[DUTY_BITS-1:0];
                  end
                  num_in   = NUM_BITS'(rate_ff);
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = ST_FREQ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_START;
         rate_ff       <= RATE_RESET;
         first_rise_ff <= '0;
         fall_ff       <= '0;
         on_ff         <= '0;
         per_ff        <= '0;
         arm_ff        <= 1'b0;
         meas_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         first_rise_ff <= first_rise_in;
         fall_ff       <= fall_in;
         on_ff         <= on_in;
         per_ff        <= per_in;
         arm_ff        <= arm_in;
         meas_ff       <= meas_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            rate_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      duty_ff <= duty_in;
      if (out_load) begin
         o_arm_ff  <= arm_ff;
         o_meas_ff <= meas_ff;
         o_on_ff   <= on_ff;
         o_per_ff  <= per_ff;
         o_duty_ff <= duty_ff;
         // quotient of the frequency pass, now complete
         o_freq_ff <= per_zero ? '0 : num_ff[RATE_BITS-1:0];
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ch.ready)
      else $error("request taken while a measurement is in progress");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.duty_q8 <= DUTY_FULL))
      else $error("duty above 100 percent");

   a_meas_arms_rise: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.result_valid) |-> rsp_ch.arm_rising)
      else $error("completed measurement must arm a rising edge");

   a_freq_bound: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_ch.frequency_hz <= rate_ff))
      else $error("frequency exceeds tick rate");

   a_div_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUTY) |-> (step_ff <= LAST_STEP))
      else $error("divider step count overran");
`endif

endmodule

`default_nettype wire
